### sv/ssg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_pkg: shared types and constants of the shell sort block
// Payload structs, store geometry, gap mode codes and sequencer control.
// ----------------------------------------------------------------------------
package ssg_pkg;

  // Store geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int GAP_W  = 7;
  localparam int CMP_W  = 16;
  localparam int MODE_W = 3;

  // Gap sequence codes
  localparam logic [MODE_W-1:0] MODE_INSERTION = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HALVING   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_KNUTH     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HIBBARD   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CIURA     = 3'd4;

  typedef struct packed {
    logic signed [31:0] value_in;
    logic               last_in;
  } ssg_in_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [ADDR_W-1:0]  position;
    logic [CMP_W-1:0]   compare_count;
    logic               last_out;
  } ssg_out_t;

  // Commands from the sequencer to the gap generator
  typedef struct packed {
    logic start;
    logic advance;
  } ssg_gap_ctl_t;

endpackage

### sv/ssg_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_store: element store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssg_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ssg_pkg::ADDR_W-1:0] waddr,
  input  logic signed [31:0]         wdata,
  input  logic [ssg_pkg::ADDR_W-1:0] raddr,
  output logic signed [31:0]         rdata
);

  logic signed [31:0] mem [ssg_pkg::DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/ssg_gap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_gap: gap sequence generator
// Holds the current gap; start loads the largest gap for the set size,
// advance steps to the next smaller one. Zero means the sequence is done.
// ----------------------------------------------------------------------------
module ssg_gap (
  input  logic                       clk,
  input  logic                       rst,
  input  ssg_pkg::ssg_gap_ctl_t      ctl,
  input  logic [ssg_pkg::MODE_W-1:0] mode,
  input  logic [ssg_pkg::CNT_W-1:0]  n,
  output logic [ssg_pkg::GAP_W-1:0]  gap
);

  logic [ssg_pkg::GAP_W-1:0] first_gap;
  logic [ssg_pkg::GAP_W-1:0] step_gap;

  // Largest gap of the selected sequence for a set of n elements
  always_comb begin
    first_gap = '0;
    case (mode)
      ssg_pkg::MODE_INSERTION: first_gap = 7'd1;
      ssg_pkg::MODE_HALVING:   first_gap = ssg_pkg::GAP_W'(n >> 1);
      ssg_pkg::MODE_KNUTH: begin
        // largest 3h+1 term below n/3, else 1
        if (n >= 7'd42)      first_gap = 7'd13;
        else if (n >= 7'd15) first_gap = 7'd4;
        else                 first_gap = 7'd1;
      end
      ssg_pkg::MODE_HIBBARD: begin
        // largest 2^k-1 term below n/2, else 1
        if (n >= 7'd64)      first_gap = 7'd31;
        else if (n >= 7'd32) first_gap = 7'd15;
        else if (n >= 7'd16) first_gap = 7'd7;
        else if (n >= 7'd8)  first_gap = 7'd3;
        else                 first_gap = 7'd1;
      end
      default: begin
        // Ciura table, gaps of at least n skipped
        if (n > 7'd57)      first_gap = 7'd57;
        else if (n > 7'd23) first_gap = 7'd23;
        else if (n > 7'd10) first_gap = 7'd10;
        else if (n > 7'd4)  first_gap = 7'd4;
        else if (n > 7'd1)  first_gap = 7'd1;
        else                first_gap = 7'd0;
      end
    endcase
  end

  // Next smaller gap of the selected sequence
  always_comb begin
    step_gap = '0;
    case (mode) inside
      ssg_pkg::MODE_INSERTION: step_gap = '0;
      ssg_pkg::MODE_HALVING,
      ssg_pkg::MODE_HIBBARD:   step_gap = gap >> 1;
      ssg_pkg::MODE_KNUTH: begin
        case (gap)
          7'd13:   step_gap = 7'd4;
          7'd4:    step_gap = 7'd1;
          default: step_gap = 7'd0;
        endcase
      end
      default: begin
        case (gap)
          7'd57:   step_gap = 7'd23;
          7'd23:   step_gap = 7'd10;
          7'd10:   step_gap = 7'd4;
          7'd4:    step_gap = 7'd1;
          default: step_gap = 7'd0;
        endcase
      end
    endcase
  end

  // Hold, load or step the gap
  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
    end else if (ctl.start) begin
      gap <= first_gap;
    end else if (ctl.advance) begin
      gap <= step_gap;
    end
  end

endmodule

### sv/shell_sort_gap_sequences.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_sort_gap_sequences: shell sort with selectable gap sequence
// Loads a set of signed values, sorts it in place with gapped insertion
// passes and streams the sorted set out with positions and compare count.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid / in_ready       ssg_in_t  (value_in, last_in)
//  out       output     out_valid / out_ready     ssg_out_t (value_out, position,
//                                                  compare_count, last_out)
//  cfg       input      cfg_we                    cfg_wdata (gap_mode)
//
// Loading accepts requests back to back. The sort runs one compare per cycle
// on the shared comparator, plus S_OUTER and S_HOLD per outer step, S_PLACE
// when the held value moves to the front of its chain, and S_NEXT_GAP per gap
// and at the close; every access goes through the single read port of the
// store. Each result is read in S_EMIT_RD and held in S_EMIT_OUT until taken.
// in_ready is low from the last request until the final result is taken.
// Reset is synchronous and sets gap_mode to Ciura.
// ----------------------------------------------------------------------------
module shell_sort_gap_sequences (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ssg_pkg::ssg_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ssg_pkg::ssg_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [ssg_pkg::MODE_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_LOAD, S_NEXT_GAP, S_OUTER, S_HOLD, S_CMP, S_PLACE, S_EMIT_RD, S_EMIT_OUT
  } state_t;

  state_t                      state;
  logic [ssg_pkg::MODE_W-1:0]  gap_mode;
  logic [ssg_pkg::CNT_W-1:0]   element_count;
  logic [ssg_pkg::CNT_W-1:0]   count_next;
  logic [ssg_pkg::CNT_W-1:0]   set_size;
  logic [ssg_pkg::CMP_W-1:0]   comparison_counter;
  logic [ssg_pkg::GAP_W-1:0]   outer_index;
  logic [ssg_pkg::GAP_W-1:0]   inner_index;
  logic [ssg_pkg::ADDR_W-1:0]  emit_index;
  logic signed [31:0]          held_value;

  logic                        mem_we;
  logic [ssg_pkg::ADDR_W-1:0]  mem_waddr;
  logic signed [31:0]          mem_wdata;
  logic [ssg_pkg::ADDR_W-1:0]  mem_raddr;
  logic signed [31:0]          mem_rdata;

  ssg_pkg::ssg_gap_ctl_t       gap_ctl;
  logic [ssg_pkg::GAP_W-1:0]   current_gap;

  logic                        in_acc;
  logic                        out_acc;
  logic                        store_room;
  logic                        shift_up;
  logic [ssg_pkg::GAP_W-1:0]   inner_next;
  logic [ssg_pkg::GAP_W-1:0]   inner_far;
  logic                        keep_going;
  logic                        emit_last;

  assign in_ready   = (state == S_LOAD);
  assign in_acc     = in_valid && in_ready;
  assign out_acc    = out_valid && out_ready;
  assign store_room = (element_count < ssg_pkg::CNT_W'(ssg_pkg::DEPTH));
  assign count_next = element_count + ssg_pkg::CNT_W'(store_room);

  // Shared comparator and index steps of the insertion loop
  assign shift_up   = (mem_rdata > held_value);
  assign inner_next = inner_index - current_gap;
  assign inner_far  = inner_next - current_gap;
  assign keep_going = (inner_next >= current_gap);
  assign emit_last  = ((ssg_pkg::CNT_W'(emit_index) + 1'b1) == set_size);

  ssg_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ssg_gap u_gap (
    .clk  (clk),
    .rst  (rst),
    .ctl  (gap_ctl),
    .mode (gap_mode),
    .n    (count_next),
    .gap  (current_gap)
  );

  // Drive store ports and gap commands from the sequencer state
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = inner_index[ssg_pkg::ADDR_W-1:0];
    mem_wdata       = held_value;
    mem_raddr       = outer_index[ssg_pkg::ADDR_W-1:0];
    gap_ctl.start   = 1'b0;
    gap_ctl.advance = 1'b0;
    unique case (state)
      S_LOAD: begin
        mem_we        = in_acc && store_room;
        mem_waddr     = element_count[ssg_pkg::ADDR_W-1:0];
        mem_wdata     = in_data.value_in;
        gap_ctl.start = in_acc && in_data.last_in;
      end
      S_NEXT_GAP: begin
      end
      S_OUTER: begin
        gap_ctl.advance = (ssg_pkg::CNT_W'(outer_index) >= set_size);
      end
      S_HOLD: begin
        mem_raddr = inner_next[ssg_pkg::ADDR_W-1:0];
      end
      S_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = shift_up ? mem_rdata : held_value;
        mem_raddr = inner_far[ssg_pkg::ADDR_W-1:0];
      end
      S_PLACE: begin
        mem_we = 1'b1;
      end
      S_EMIT_RD: begin
        mem_raddr = emit_index;
      end
      S_EMIT_OUT: begin
        mem_raddr = emit_index + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_LOAD;
      gap_mode           <= ssg_pkg::MODE_CIURA;
      element_count      <= '0;
      set_size           <= '0;
      comparison_counter <= '0;
      outer_index        <= '0;
      inner_index        <= '0;
      emit_index         <= '0;
      held_value         <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        gap_mode <= cfg_wdata;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            element_count <= count_next;
            if (in_data.last_in) begin
              set_size           <= count_next;
              comparison_counter <= '0;
              state              <= S_NEXT_GAP;
            end
          end
        end
        S_NEXT_GAP: begin
          if (current_gap == '0) begin
            emit_index <= '0;
            state      <= S_EMIT_RD;
          end else begin
            outer_index <= current_gap;
            state       <= S_OUTER;
          end
        end
        S_OUTER: begin
          if (ssg_pkg::CNT_W'(outer_index) >= set_size) begin
            state <= S_NEXT_GAP;
          end else begin
            inner_index <= outer_index;
            state       <= S_HOLD;
          end
        end
        S_HOLD: begin
          held_value <= mem_rdata;
          state      <= S_CMP;
        end
        S_CMP: begin
          if (comparison_counter != '1) begin
            comparison_counter <= comparison_counter + 1'b1;
          end
          if (shift_up) begin
            inner_index <= inner_next;
            state       <= keep_going ? S_CMP : S_PLACE;
          end else begin
            outer_index <= outer_index + 1'b1;
            state       <= S_OUTER;
          end
        end
        S_PLACE: begin
          outer_index <= outer_index + 1'b1;
          state       <= S_OUTER;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          // load the result register, then advance once it is taken
          if (!out_valid) begin
            out_valid              <= 1'b1;
            out_data.value_out     <= mem_rdata;
            out_data.position      <= emit_index;
            out_data.compare_count <= comparison_counter;
            out_data.last_out      <= emit_last;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (emit_last) begin
              element_count <= '0;
              state         <= S_LOAD;
            end else begin
              emit_index <= emit_index + 1'b1;
              state      <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTH
  // Input and output sides never overlap
  a_no_overlap : assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("in_ready high while a result is pending");

  // Compare only at an inner index that reaches back by one gap
  a_inner_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (inner_index >= current_gap && current_gap != '0))
    else $error("compare below the current gap");

  // Fill count stays within the store
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    element_count <= ssg_pkg::CNT_W'(ssg_pkg::DEPTH))
    else $error("element count beyond store depth");

  // Taking the final result reopens the input
  a_end_of_run : assert property (@(posedge clk) disable iff (rst)
    (out_acc && out_data.last_out) |=> (in_ready && element_count == '0))
    else $error("input not reopened after final result");
`endif

endmodule

### verif/tb_shell_sort_gap_sequences.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shell_sort_gap_sequences: self-checking bench for the shell sort block
// Loads sets of signed values under every gap mode, predicts the sorted
// stream, positions and compare counts, and checks each result in order
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_shell_sort_gap_sequences;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 20;
  localparam int IDLE_LIMIT     = 20000;
  localparam int RANDOM_ITEMS   = 130;
  localparam int MAX_REPORTS    = 10;

  // Highest mode code; the spare ones fold onto Ciura
  localparam logic [ssg_pkg::MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  // Receiver stall styles
  localparam int READY_ALWAYS = 0;
  localparam int READY_HALF   = 1;
  localparam int READY_SPARSE = 2;

  localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  ssg_pkg::ssg_in_t           in_data   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  ssg_pkg::ssg_out_t          out_data;
  logic                       cfg_we    = 1'b0;
  logic [ssg_pkg::MODE_W-1:0] cfg_wdata = '0;

  // Predictor state: mode, the set being loaded and the sort scratch
  logic [ssg_pkg::MODE_W-1:0] active_mode = ssg_pkg::MODE_CIURA;
  logic signed [31:0] load_buf [ssg_pkg::DEPTH];
  int                 load_count = 0;
  int                 compare_total;
  int                 ciura_gaps [9] = '{1750, 701, 301, 132, 57, 23, 10, 4, 1};

  ssg_pkg::ssg_out_t sorted_pending [$];
  int       mismatch_count = 0;
  int       result_index   = 0;
  int       burst_left     = 0;
  int       idle_cycles    = 0;
  int       ready_style    = READY_ALWAYS;
  int       ready_left     = 0;

  shell_sort_gap_sequences u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // One gapped insertion pass over the first n loaded values
  function automatic void insertion_pass(int n, int gap);
    int i;
    int j;
    logic signed [31:0] held;
    logic moving;
    for (i = gap; i < n; i++) begin
      held = load_buf[i];
      j = i;
      moving = 1'b1;
      while (moving && j >= gap) begin
        if (compare_total < {ssg_pkg::CMP_W{1'b1}}) compare_total++;
        if (load_buf[j - gap] > held) begin
          load_buf[j] = load_buf[j - gap];
          j -= gap;
        end else begin
          moving = 1'b0;
        end
      end
      load_buf[j] = held;
    end
  endfunction

  // Sort the loaded set under the active mode and queue its results
  function automatic void predict_sorted_run();
    int n;
    int g;
    int k;
    int limit;
    int count;
    int seq [16];
    ssg_pkg::ssg_out_t res;
    n = load_count;
    compare_total = 0;
    case (active_mode) inside
      ssg_pkg::MODE_INSERTION: insertion_pass(n, 1);
      ssg_pkg::MODE_HALVING: begin
        for (g = n / 2; g > 0; g /= 2) insertion_pass(n, g);
      end
      ssg_pkg::MODE_KNUTH, ssg_pkg::MODE_HIBBARD: begin
        limit = (active_mode == ssg_pkg::MODE_KNUTH) ? n / 3 : n / 2;
        g = 1;
        count = 0;
        while (g < limit && count < 16) begin
          seq[count] = g;
          count++;
          g = (active_mode == ssg_pkg::MODE_KNUTH) ? 3 * g + 1 : 2 * g + 1;
        end
        // always finish with a gap of one
        if (count == 0) begin
          seq[0] = 1;
          count = 1;
        end
        for (k = count - 1; k >= 0; k--) insertion_pass(n, seq[k]);
      end
      default: begin
        for (k = 0; k < 9; k++) begin
          if (ciura_gaps[k] < n) insertion_pass(n, ciura_gaps[k]);
        end
      end
    endcase
    for (k = 0; k < n; k++) begin
      res.value_out     = load_buf[k];
      res.position      = k[ssg_pkg::ADDR_W-1:0];
      res.compare_count = compare_total[ssg_pkg::CMP_W-1:0];
      res.last_out      = (k == n - 1);
      sorted_pending.push_back(res);
    end
  endfunction

  // Drive one request, hold it until accepted, then idle between bursts
  task automatic send_request(input logic signed [31:0] value, input logic last);
    ssg_pkg::ssg_in_t req;
    int gap;
    req.value_in = value;
    req.last_in  = last;
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    // store or drop, and sort on the final element
    if (load_count < ssg_pkg::DEPTH) begin
      load_buf[load_count] = value;
      load_count++;
    end
    if (last) begin
      predict_sorted_run();
      load_count = 0;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every queued result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sorted_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gap_mode(input logic [ssg_pkg::MODE_W-1:0] mode);
    wait_drained();
    cfg_wdata <= mode;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_mode = mode;
  endtask

  // Reset mode is Ciura: single element, then a pair of the maximum and zero
  task automatic test_reset_mode();
    send_request(VALUE_MIN, 1'b1);
    send_request(VALUE_MAX, 1'b0);
    send_request(32'sd0, 1'b1);
  endtask

  // Every mode code, spare ones included, on a descending set of three
  task automatic test_gap_modes();
    for (int m = ssg_pkg::MODE_INSERTION; m <= MODE_SPARE_LAST; m++) begin
      write_gap_mode(m[ssg_pkg::MODE_W-1:0]);
      send_request(VALUE_MAX, 1'b0);
      send_request(-32'sd1, 1'b0);
      send_request(VALUE_MIN, 1'b1);
    end
  endtask

  // Random sets: first one overflows the store, a few near full, most small
  task automatic test_random_sets();
    int sent;
    int size;
    int i;
    logic signed [31:0] value;
    sent = 0;
    size = ssg_pkg::DEPTH + 2;
    while (sent < RANDOM_ITEMS) begin
      for (i = 0; i < size; i++) begin
        case ($urandom_range(0, 7))
          0: value = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
          1, 2: value = $signed($urandom_range(0, 6)) - 3;
          default: value = $urandom;
        endcase
        send_request(value, i == size - 1);
      end
      sent += size;
      case ($urandom_range(0, 3))
        0: write_gap_mode(ssg_pkg::MODE_W'($urandom_range(0, (1 << ssg_pkg::MODE_W) - 1)));
        1: wait_drained();
        default: ;
      endcase
      size = ($urandom_range(0, 9) == 0)
             ? $urandom_range(ssg_pkg::DEPTH - 2, ssg_pkg::DEPTH + 2)
             : $urandom_range(1, 10);
    end
  endtask

  // Stall the result channel in phases of varying density
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_style = $urandom_range(READY_ALWAYS, READY_SPARSE);
      ready_left  = $urandom_range(8, 40);
    end else begin
      ready_left--;
    end
    case (ready_style)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_HALF:   out_ready <= $urandom_range(0, 1);
      default:      out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare each accepted result against the oldest prediction
  always @(posedge clk) begin
    ssg_pkg::ssg_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (sorted_pending.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result %0d: value %0d pos %0d cmp %0d last %0d",
                   result_index, out_data.value_out, out_data.position,
                   out_data.compare_count, out_data.last_out);
      end else begin
        want = sorted_pending.pop_front();
        if (out_data.value_out !== want.value_out || out_data.position !== want.position ||
            out_data.compare_count !== want.compare_count ||
            out_data.last_out !== want.last_out) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch result %0d: value %0d/%0d pos %0d/%0d cmp %0d/%0d last %0d/%0d",
                     result_index, want.value_out, out_data.value_out, want.position,
                     out_data.position, want.compare_count, out_data.compare_count,
                     want.last_out, out_data.last_out);
        end
      end
      result_index++;
    end
  end

  // Abort when no request or result moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_mode();
    test_gap_modes();
    test_random_sets();
    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
